[design/dttp_pkg.sv]
package dttp_pkg;

    // field widths of one item
    localparam int CHAR_W   = 8;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int COUNT_W  = 5;
    localparam int FIELD_W  = 3;
    localparam int PROD_W   = 18;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_YEAR_MIN = 1'b0;
    localparam logic REG_YEAR_MAX = 1'b1;

    // character codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2f;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3a;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    // field codes
    localparam logic [FIELD_W-1:0] FLD_DAY    = 3'd0;
    localparam logic [FIELD_W-1:0] FLD_MONTH  = 3'd1;
    localparam logic [FIELD_W-1:0] FLD_YEAR   = 3'd2;
    localparam logic [FIELD_W-1:0] FLD_HOUR   = 3'd3;
    localparam logic [FIELD_W-1:0] FLD_MINUTE = 3'd4;

    // limits
    localparam logic [COUNT_W-1:0] LEN_MIN   = 5'd12;
    localparam logic [COUNT_W-1:0] LEN_MAX   = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
    localparam logic [YEAR_W-1:0]  ACC_MAX   = 14'd16383;
    localparam logic [YEAR_W-1:0]  DAY_LIMIT    = 14'd32;
    localparam logic [YEAR_W-1:0]  MONTH_LIMIT  = 14'd13;
    localparam logic [YEAR_W-1:0]  HOUR_LIMIT   = 14'd24;
    localparam logic [YEAR_W-1:0]  MINUTE_LIMIT = 14'd60;

    // reset date
    localparam logic [DAY_W-1:0]    RST_DAY    = 5'd1;
    localparam logic [MONTH_W-1:0]  RST_MONTH  = 4'd1;
    localparam logic [YEAR_W-1:0]   RST_YEAR   = 14'd1970;
    localparam logic [YEAR_W-1:0]   RST_YEAR_MAX = 14'd2020;

    typedef struct packed {
        logic [YEAR_W-1:0] year_min;
        logic [YEAR_W-1:0] year_max;
    } cfg_t;

    // separator that closes each field
    function automatic logic [CHAR_W-1:0] field_sep(input logic [FIELD_W-1:0] fidx);
        logic [CHAR_W-1:0] sep;
        case (fidx)
            FLD_DAY:   sep = CH_SLASH;
            FLD_MONTH: sep = CH_SLASH;
            FLD_YEAR:  sep = CH_SPACE;
            default:   sep = CH_COLON;
        endcase
        return sep;
    endfunction

endpackage

[design/dttp_if.sv]
interface dttp_in_if;
    import dttp_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              is_last;

    modport source (output valid, char_code, is_last, input ready);
    modport sink   (input valid, char_code, is_last, output ready);
endinterface

interface dttp_out_if;
    import dttp_pkg::*;

    logic                valid;
    logic                ready;
    logic                accepted;
    logic [DAY_W-1:0]    day_out;
    logic [MONTH_W-1:0]  month_out;
    logic [YEAR_W-1:0]   year_out;
    logic [HOUR_W-1:0]   hour_out;
    logic [MINUTE_W-1:0] minute_out;

    modport source (output valid, accepted, day_out, month_out, year_out, hour_out,
                    minute_out, input ready);
    modport sink   (input valid, accepted, day_out, month_out, year_out, hour_out,
                    minute_out, output ready);
endinterface

[design/dttp_cfg_regs.sv]
module dttp_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dttp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [dttp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dttp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output dttp_pkg::cfg_t                     cfg
);
    import dttp_pkg::*;

    logic [YEAR_W-1:0] year_min_reg;
    logic [YEAR_W-1:0] year_max_reg;
    logic              wr_en;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_min_reg <= RST_YEAR;
            year_max_reg <= RST_YEAR_MAX;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_YEAR_MIN: year_min_reg <= pwdata[YEAR_W-1:0];
                REG_YEAR_MAX: year_max_reg <= pwdata[YEAR_W-1:0];
                default:      year_min_reg <= year_min_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_sel)
            REG_YEAR_MIN: prdata = {{(APB_DATA_W-YEAR_W){1'b0}}, year_min_reg};
            REG_YEAR_MAX: prdata = {{(APB_DATA_W-YEAR_W){1'b0}}, year_max_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.year_min = year_min_reg;
    assign cfg.year_max = year_max_reg;

endmodule

[design/date_time_text_parser.sv]
// a result beat is set in the result register once the final character leaves the input register
// throughput: one character per cycle, set by the single parse-state update per cycle, but a final character can stall
// the input register stays free while a result waits, unless it holds a final character
// reset: stored date 1/1/1970 00:00, year limits 1970..2020, parse state cleared
module date_time_text_parser (
    input  logic                               clk,
    input  logic                               rst_n,
    dttp_in_if.sink                            in_ch,
    dttp_out_if.source                         out_ch,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dttp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [dttp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [dttp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import dttp_pkg::*;

    cfg_t cfg;

    // input register
    logic              s1_valid_reg;
    logic [CHAR_W-1:0] s1_char_reg;
    logic              s1_last_reg;

    // parse state
    logic [COUNT_W-1:0] cnt_reg,  cnt_next;
    logic [FIELD_W-1:0] fidx_reg, fidx_next;
    logic [YEAR_W-1:0]  acc_reg,  acc_next;
    logic               seen_reg, seen_next;
    logic               stop_reg, stop_next;
    logic               bad_reg,  bad_next;
    logic [DAY_W-1:0]   pday_reg,   pday_next;
    logic [MONTH_W-1:0] pmonth_reg, pmonth_next;
    logic [YEAR_W-1:0]  pyear_reg,  pyear_next;
    logic [HOUR_W-1:0]  phour_reg,  phour_next;

    // stored date
    logic [DAY_W-1:0]    sday_reg;
    logic [MONTH_W-1:0]  smonth_reg;
    logic [YEAR_W-1:0]   syear_reg;
    logic [HOUR_W-1:0]   shour_reg;
    logic [MINUTE_W-1:0] sminute_reg;

    // result register
    logic                out_valid_reg;
    logic                out_acc_reg;

    logic              advance;
    logic              is_digit;
    logic              allowed;
    logic              in_range;
    logic              ok;
    logic [PROD_W-1:0] prod;

    dttp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake: non-final characters always move on
    assign advance     = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_char_reg <= in_ch.char_code;
            s1_last_reg <= in_ch.is_last;
        end
    end

    // character classes
    assign is_digit = s1_char_reg inside {[CH_ZERO:CH_NINE]};
    assign allowed  = is_digit || s1_char_reg inside {CH_SLASH, CH_COLON, CH_SPACE};
    assign prod     = ({{(PROD_W-YEAR_W){1'b0}}, acc_reg} << 3)
                    + ({{(PROD_W-YEAR_W){1'b0}}, acc_reg} << 1)
                    + {{(PROD_W-4){1'b0}}, s1_char_reg[3:0]};

    // range of the field being closed
    always_comb
    begin
        case (fidx_reg)
            FLD_DAY:   in_range = (acc_reg >= 14'd1) && (acc_reg < DAY_LIMIT);
            FLD_MONTH: in_range = (acc_reg >= 14'd1) && (acc_reg < MONTH_LIMIT);
            FLD_YEAR:  in_range = (acc_reg >= cfg.year_min) && (acc_reg <= cfg.year_max);
            default:   in_range = acc_reg < HOUR_LIMIT;
        endcase
    end

    // parse-state update for one character
    always_comb
    begin
        cnt_next    = (cnt_reg < COUNT_MAX) ? cnt_reg + 5'd1 : cnt_reg;
        fidx_next   = fidx_reg;
        acc_next    = acc_reg;
        seen_next   = seen_reg;
        stop_next   = stop_reg;
        bad_next    = bad_reg;
        pday_next   = pday_reg;
        pmonth_next = pmonth_reg;
        pyear_next  = pyear_reg;
        phour_next  = phour_reg;
        if (!bad_reg)
        begin
            if (!allowed)
            begin
                bad_next = 1'b1;
            end
            else if ((fidx_reg < FLD_MINUTE) && (s1_char_reg == field_sep(fidx_reg)))
            begin
                // separator closes the field
                if (!seen_reg || !in_range)
                begin
                    bad_next = 1'b1;
                end
                else
                begin
                    case (fidx_reg)
                        FLD_DAY:   pday_next   = acc_reg[DAY_W-1:0];
                        FLD_MONTH: pmonth_next = acc_reg[MONTH_W-1:0];
                        FLD_YEAR:  pyear_next  = acc_reg;
                        default:   phour_next  = acc_reg[HOUR_W-1:0];
                    endcase
                    fidx_next = fidx_reg + 3'd1;
                end
                acc_next  = '0;
                seen_next = 1'b0;
                stop_next = 1'b0;
            end
            else if (is_digit)
            begin
                if (!stop_reg)
                begin
                    if (prod > {{(PROD_W-YEAR_W){1'b0}}, ACC_MAX})
                    begin
                        bad_next = 1'b1;
                        acc_next = ACC_MAX;
                    end
                    else
                    begin
                        acc_next = prod[YEAR_W-1:0];
                    end
                    seen_next = 1'b1;
                end
            end
            else if (seen_reg)
            begin
                stop_next = 1'b1;
            end
            else if (s1_char_reg != CH_SPACE)
            begin
                bad_next = 1'b1;
            end
        end
    end

    // acceptance on the final character
    assign ok = !bad_next && (cnt_next >= LEN_MIN) && (cnt_next <= LEN_MAX)
              && (fidx_next == FLD_MINUTE) && seen_next && (acc_next < MINUTE_LIMIT);

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            fidx_reg   <= FLD_DAY;
            acc_reg    <= '0;
            seen_reg   <= 1'b0;
            stop_reg   <= 1'b0;
            bad_reg    <= 1'b0;
            pday_reg   <= '0;
            pmonth_reg <= '0;
            pyear_reg  <= '0;
            phour_reg  <= '0;
        end
        else if (advance)
        begin
            if (s1_last_reg)
            begin
                cnt_reg    <= '0;
                fidx_reg   <= FLD_DAY;
                acc_reg    <= '0;
                seen_reg   <= 1'b0;
                stop_reg   <= 1'b0;
                bad_reg    <= 1'b0;
                pday_reg   <= '0;
                pmonth_reg <= '0;
                pyear_reg  <= '0;
                phour_reg  <= '0;
            end
            else
            begin
                cnt_reg    <= cnt_next;
                fidx_reg   <= fidx_next;
                acc_reg    <= acc_next;
                seen_reg   <= seen_next;
                stop_reg   <= stop_next;
                bad_reg    <= bad_next;
                pday_reg   <= pday_next;
                pmonth_reg <= pmonth_next;
                pyear_reg  <= pyear_next;
                phour_reg  <= phour_next;
            end
        end
    end

    // stored date, replaced on an accepted string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sday_reg    <= RST_DAY;
            smonth_reg  <= RST_MONTH;
            syear_reg   <= RST_YEAR;
            shour_reg   <= '0;
            sminute_reg <= '0;
        end
        else if (advance && s1_last_reg && ok)
        begin
            sday_reg    <= pday_reg;
            smonth_reg  <= pmonth_reg;
            syear_reg   <= pyear_reg;
            shour_reg   <= phour_reg;
            sminute_reg <= acc_next[MINUTE_W-1:0];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_acc_reg   <= 1'b0;
        end
        else if (advance && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
            out_acc_reg   <= ok;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result beat reads the stored date, which holds until the next final character
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.accepted   = out_acc_reg;
    assign out_ch.day_out    = sday_reg;
    assign out_ch.month_out  = smonth_reg;
    assign out_ch.year_out   = syear_reg;
    assign out_ch.hour_out   = shour_reg;
    assign out_ch.minute_out = sminute_reg;

endmodule

[tb/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dttp_pkg::*;

    // one date beat as seen on the result channel
    typedef struct packed {
        logic                accepted;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } date_result_t;

    localparam logic [APB_ADDR_W-1:0] ADDR_YEAR_MIN = {REG_YEAR_MIN, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_YEAR_MAX = {REG_YEAR_MAX, 2'b00};

    // parses the character stream on its own and keeps the dates still to come
    class date_scoreboard;
        logic [YEAR_W-1:0]   yr_lo;
        logic [YEAR_W-1:0]   yr_hi;
        logic [DAY_W-1:0]    kept_day;
        logic [MONTH_W-1:0]  kept_month;
        logic [YEAR_W-1:0]   kept_year;
        logic [HOUR_W-1:0]   kept_hour;
        logic [MINUTE_W-1:0] kept_minute;
        logic [COUNT_W-1:0]  n_chars;
        logic [FIELD_W-1:0]  cur_field;
        int unsigned         acc;
        bit                  seen;
        bit                  stopped;
        bit                  bad;
        int unsigned         closed [4];
        date_result_t        expected_dates [$];
        int                  errors;
        int                  n_strings;
        int                  n_accepted;

        function new();
            yr_lo       = RST_YEAR;
            yr_hi       = RST_YEAR_MAX;
            kept_day    = RST_DAY;
            kept_month  = RST_MONTH;
            kept_year   = RST_YEAR;
            kept_hour   = '0;
            kept_minute = '0;
            errors      = 0;
            n_strings   = 0;
            n_accepted  = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            n_chars   = '0;
            cur_field = FLD_DAY;
            acc       = 0;
            seen      = 0;
            stopped   = 0;
            bad       = 0;
            foreach (closed[i])
                closed[i] = 0;
        endfunction

        function void set_limits(logic [YEAR_W-1:0] lo, logic [YEAR_W-1:0] hi);
            yr_lo = lo;
            yr_hi = hi;
        endfunction

        // advance the parse by one accepted character, queue a date on the final one
        function void note_char(logic [CHAR_W-1:0] c, logic is_end);
            logic [CHAR_W-1:0] sep;
            bit                is_digit;
            bit                ok;
            int unsigned       v;
            date_result_t      r;

            is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
            case (cur_field)
                FLD_DAY, FLD_MONTH: sep = CH_SLASH;
                FLD_YEAR:           sep = CH_SPACE;
                default:            sep = CH_COLON;
            endcase

            if (n_chars < COUNT_MAX)
                n_chars++;

            if (!bad)
            begin
                if (!(is_digit || c == CH_SLASH || c == CH_COLON || c == CH_SPACE))
                begin
                    bad = 1;
                end
                else if (cur_field < FLD_MINUTE && c == sep)
                begin
                    // separator closes the field
                    case (cur_field)
                        FLD_DAY:   ok = acc >= 1 && acc < DAY_LIMIT;
                        FLD_MONTH: ok = acc >= 1 && acc < MONTH_LIMIT;
                        FLD_YEAR:  ok = acc >= yr_lo && acc <= yr_hi;
                        default:   ok = acc < HOUR_LIMIT;
                    endcase
                    if (seen && ok)
                    begin
                        closed[cur_field] = acc;
                        cur_field++;
                    end
                    else
                    begin
                        bad = 1;
                    end
                    acc     = 0;
                    seen    = 0;
                    stopped = 0;
                end
                else if (is_digit)
                begin
                    if (!stopped)
                    begin
                        v = acc * 10 + (c - CH_ZERO);
                        if (v > ACC_MAX)
                        begin
                            bad = 1;
                            acc = ACC_MAX;
                        end
                        else
                        begin
                            acc = v;
                        end
                        seen = 1;
                    end
                end
                else if (seen)
                begin
                    stopped = 1;
                end
                else if (c != CH_SPACE)
                begin
                    bad = 1;
                end
            end

            if (is_end)
            begin
                ok = !bad && n_chars >= LEN_MIN && n_chars <= LEN_MAX &&
                     cur_field == FLD_MINUTE && seen && acc < MINUTE_LIMIT;
                if (ok)
                begin
                    kept_day    = DAY_W'(closed[FLD_DAY]);
                    kept_month  = MONTH_W'(closed[FLD_MONTH]);
                    kept_year   = YEAR_W'(closed[FLD_YEAR]);
                    kept_hour   = HOUR_W'(closed[FLD_HOUR]);
                    kept_minute = MINUTE_W'(acc);
                    n_accepted++;
                end
                r.accepted = ok;
                r.day      = kept_day;
                r.month    = kept_month;
                r.year     = kept_year;
                r.hour     = kept_hour;
                r.minute   = kept_minute;
                expected_dates.push_back(r);
                n_strings++;
                clear_parse();
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // match a date beat against the oldest expected one
        function void check_result(date_result_t got);
            date_result_t want;

            if (expected_dates.size() == 0)
            begin
                $display("%0t: unexpected date beat, expected none, got %0b %0d/%0d/%0d %0d:%0d",
                         $time, got.accepted, got.day, got.month, got.year, got.hour,
                         got.minute);
                errors++;
                return;
            end
            want = expected_dates.pop_front();
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("day", want.day, got.day);
            compare_field("month", want.month, got.month);
            compare_field("year", want.year, got.year);
            compare_field("hour", want.hour, got.hour);
            compare_field("minute", want.minute, got.minute);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    dttp_in_if  in_bus ();
    dttp_out_if out_bus ();

    date_time_text_parser u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_bus),
        .out_ch  (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    date_scoreboard    sb;
    date_result_t      seen_date;
    logic [CHAR_W-1:0] text_q [$];
    int                burst_left;
    int                sent_chars;
    int                rx_cycle = 0;
    int                n_settings;

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // run limit
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // receiver stall pattern, which steps through four styles of ready in turn
    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 97) % 4)
            0:       out_bus.ready <= 1'b1;
            1:       out_bus.ready <= 1'($urandom_range(0, 1));
            2:       out_bus.ready <= (rx_cycle % 13) > 8;
            default: out_bus.ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // sample both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_bus.valid && in_bus.ready)
                sb.note_char(in_bus.char_code, in_bus.is_last);
            if (out_bus.valid && out_bus.ready)
            begin
                seen_date.accepted = out_bus.accepted;
                seen_date.day      = out_bus.day_out;
                seen_date.month    = out_bus.month_out;
                seen_date.year     = out_bus.year_out;
                seen_date.hour     = out_bus.hour_out;
                seen_date.minute   = out_bus.minute_out;
                sb.check_result(seen_date);
            end
        end
    end

    // one register access, setup then access phase
    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic read_back(input logic [APB_ADDR_W-1:0] addr,
                             input logic [YEAR_W-1:0] want);
        logic [APB_DATA_W-1:0] rd;

        apb_access(1'b0, addr, '0, rd);
        if (rd[YEAR_W-1:0] != want)
        begin
            $display("%0t: register at %0d mismatch, expected %0d, got %0d",
                     $time, addr, want, rd[YEAR_W-1:0]);
            sb.errors++;
        end
    endtask

    task automatic set_year_limits(input logic [YEAR_W-1:0] lo, input logic [YEAR_W-1:0] hi);
        logic [APB_DATA_W-1:0] rd;

        apb_access(1'b1, ADDR_YEAR_MIN, APB_DATA_W'(lo), rd);
        apb_access(1'b1, ADDR_YEAR_MAX, APB_DATA_W'(hi), rd);
        sb.set_limits(lo, hi);
        read_back(ADDR_YEAR_MIN, lo);
        read_back(ADDR_YEAR_MAX, hi);
        n_settings++;
    endtask

    // one character beat, sent in bursts with idle gaps in between
    task automatic send_char(input logic [CHAR_W-1:0] c, input logic is_end);
        if (burst_left <= 0)
        begin
            repeat ($urandom_range(1, 5))
            begin
                in_bus.valid <= 1'b0;
                @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
        end
        in_bus.valid     <= 1'b1;
        in_bus.char_code <= c;
        in_bus.is_last   <= is_end;
        do
            @(posedge clk);
        while (!in_bus.ready);
        @(negedge clk);
        burst_left--;
        sent_chars++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_char(text_q[i], i == text_q.size() - 1);
        text_q.delete();
    endtask

    // let every date drain and the pipeline settle
    task automatic wait_quiet();
        in_bus.valid <= 1'b0;
        while (sb.expected_dates.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endfunction

    function automatic void put_number(int unsigned v);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) text_q.push_back(CH_ZERO);
        put_text($sformatf("%0d", v));
    endfunction

    // optional spaces ahead of a field's digits
    function automatic void put_lead();
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 2)) text_q.push_back(CH_SPACE);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_char();
        case ($urandom_range(0, 4))
            0:       return CH_SPACE;
            1:       return CH_SLASH;
            2:       return CH_COLON;
            3:       return CH_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // non-digit after the digits, then a digit that must be ignored
    function automatic void put_stop();
        if ($urandom_range(0, 11) == 0)
        begin
            case ($urandom_range(0, 2))
                0:       text_q.push_back(CH_SPACE);
                1:       text_q.push_back(CH_SLASH);
                default: text_q.push_back(CH_COLON);
            endcase
            text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    // mostly well-formed timestamps, some out of range, damaged, cut short or noise
    task automatic send_random_string();
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned h;
        int unsigned mi;
        int unsigned kind;
        int unsigned pos;
        int unsigned keep;

        d  = $urandom_range(1, 31);
        m  = $urandom_range(1, 12);
        h  = $urandom_range(0, 23);
        mi = $urandom_range(0, 59);
        if (sb.yr_lo <= sb.yr_hi)
            y = $urandom_range(sb.yr_hi, sb.yr_lo);
        else
            y = $urandom_range(0, 9999);
        kind = $urandom_range(0, 99);

        if (kind >= 55 && kind < 70)
        begin
            case ($urandom_range(0, 8))
                0: d  = 0;
                1: d  = $urandom_range(32, 99);
                2: m  = 0;
                3: m  = $urandom_range(13, 99);
                4: y  = ($urandom_range(0, 1) && sb.yr_lo > 0) ? sb.yr_lo - 1 : sb.yr_hi + 1;
                5: h  = $urandom_range(24, 99);
                6: mi = $urandom_range(60, 99);
                7: y  = $urandom_range(16384, 99999);
                default: mi = $urandom_range(16384, 999999);
            endcase
        end

        put_lead();
        put_number(d);
        text_q.push_back(CH_SLASH);
        put_lead();
        put_number(m);
        text_q.push_back(CH_SLASH);
        put_number(y);
        text_q.push_back(CH_SPACE);
        put_lead();
        put_number(h);
        put_stop();
        text_q.push_back(CH_COLON);
        put_lead();
        put_number(mi);
        put_stop();

        if (kind >= 70 && kind < 85)
        begin
            pos = $urandom_range(0, text_q.size() - 1);
            case ($urandom_range(0, 2))
                0:       text_q[pos] = rand_char();
                1:       text_q.delete(pos);
                default: text_q.insert(pos, rand_char());
            endcase
        end
        else if (kind >= 85 && kind < 93)
        begin
            keep = $urandom_range(1, text_q.size() - 1);
            while (text_q.size() > keep)
                void'(text_q.pop_back());
        end
        else if (kind >= 93)
        begin
            text_q.delete();
            repeat ($urandom_range(1, 40)) text_q.push_back(rand_char());
        end
        send_text();
    endtask

    task automatic random_phase(input int n_chars);
        int target;

        target = sent_chars + n_chars;
        while (sent_chars < target)
            send_random_string();
    endtask

    // main sequence
    initial
    begin
        logic [YEAR_W-1:0] lim_lo [4];
        logic [YEAR_W-1:0] lim_hi [4];

        lim_lo = '{14'd0, 14'd2000, 14'd9999, 14'd0};
        lim_hi = '{14'd9999, 14'd2000, 14'd0, 14'd150};

        sb               = new();
        burst_left       = 0;
        sent_chars       = 0;
        n_settings       = 0;
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_bus.valid     = 1'b0;
        in_bus.char_code = '0;
        in_bus.is_last   = 1'b0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        read_back(ADDR_YEAR_MIN, RST_YEAR);
        read_back(ADDR_YEAR_MAX, RST_YEAR_MAX);

        // directed: largest date, a lone foreign character, shortest legal string
        @(negedge clk);
        put_text("31/12/2020 23:59");
        send_text();
        text_q.push_back(8'hff);
        send_text();
        put_text("1/1/1970 0:0");
        send_text();

        random_phase(210);
        for (int i = 0; i < 4; i++)
        begin
            wait_quiet();
            set_year_limits(lim_lo[i], lim_hi[i]);
            random_phase(210);
        end

        wait_quiet();
        repeat (6) @(posedge clk);

        $display("sent %0d characters in %0d strings, %0d accepted, %0d year limit settings",
                 sent_chars, sb.n_strings, sb.n_accepted, n_settings + 1);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
design/dttp_pkg.sv
design/dttp_if.sv
design/dttp_cfg_regs.sv
design/date_time_text_parser.sv
tb/tb.sv
